// ----- sv/lfe_pkg.sv -----
`default_nettype none
package lfe_pkg;

	localparam int unsigned SINE_STEPS_DEF    = 128;
	localparam int unsigned RANDOM_PERIOD_DEF = 10;

	localparam logic [7:0] LEVEL_FULL   = 8'd255;
	localparam logic [7:0] LEVEL_OFF    = 8'd0;
	localparam logic [7:0] RANDOM_FLOOR = 8'd50;

	localparam logic FUNC_TICK  = 1'b0;
	localparam logic FUNC_START = 1'b1;

	localparam logic [1:0] PICK_RED   = 2'd0;
	localparam logic [1:0] PICK_GREEN = 2'd1;
	localparam logic [1:0] PICK_BLUE  = 2'd2;

	typedef enum logic [2:0] {
		EFF_NONE    = 3'd0,
		EFF_SINE    = 3'd1,
		EFF_LINEAR  = 3'd2,
		EFF_RANDOM  = 3'd3,
		EFF_RAINBOW = 3'd4
	} lfe_effect_t;

	typedef struct packed {
		logic       func;
		logic [2:0] effect;
		logic [7:0] random_level;
		logic [1:0] random_pick;
	} lfe_item_t;

	typedef struct packed {
		logic [7:0] dim;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} lfe_levels_t;

	// One full cycle of 127.5 + 127.5 * sin, rounded to nearest.
	localparam logic [7:0] SINE_TABLE [128] = '{
		8'd128, 8'd134, 8'd140, 8'd146, 8'd152, 8'd158, 8'd165, 8'd170,
		8'd176, 8'd182, 8'd188, 8'd193, 8'd198, 8'd203, 8'd208, 8'd213,
		8'd218, 8'd222, 8'd226, 8'd230, 8'd234, 8'd237, 8'd240, 8'd243,
		8'd245, 8'd248, 8'd250, 8'd251, 8'd253, 8'd254, 8'd254, 8'd255,
		8'd255, 8'd255, 8'd254, 8'd254, 8'd253, 8'd251, 8'd250, 8'd248,
		8'd245, 8'd243, 8'd240, 8'd237, 8'd234, 8'd230, 8'd226, 8'd222,
		8'd218, 8'd213, 8'd208, 8'd203, 8'd198, 8'd193, 8'd188, 8'd182,
		8'd176, 8'd170, 8'd165, 8'd158, 8'd152, 8'd146, 8'd140, 8'd134,
		8'd128, 8'd121, 8'd115, 8'd109, 8'd103, 8'd97,  8'd90,  8'd85,
		8'd79,  8'd73,  8'd67,  8'd62,  8'd57,  8'd52,  8'd47,  8'd42,
		8'd37,  8'd33,  8'd29,  8'd25,  8'd21,  8'd18,  8'd15,  8'd12,
		8'd10,  8'd7,   8'd5,   8'd4,   8'd2,   8'd1,   8'd1,   8'd0,
		8'd0,   8'd0,   8'd1,   8'd1,   8'd2,   8'd4,   8'd5,   8'd7,
		8'd10,  8'd12,  8'd15,  8'd18,  8'd21,  8'd25,  8'd29,  8'd33,
		8'd37,  8'd42,  8'd47,  8'd52,  8'd57,  8'd62,  8'd67,  8'd73,
		8'd79,  8'd85,  8'd90,  8'd97,  8'd103, 8'd109, 8'd115, 8'd121
	};

	function automatic logic [7:0] mod255(input logic [7:0] x);
		return (x == 8'd255) ? 8'd0 : x;
	endfunction

endpackage
`default_nettype wire

// ----- sv/lfe_step.sv -----
`default_nettype none
module lfe_step import lfe_pkg::*; #(
	parameter int unsigned SINE_STEPS    = SINE_STEPS_DEF,
	parameter int unsigned RANDOM_PERIOD = RANDOM_PERIOD_DEF,
	localparam int unsigned PW = $clog2(SINE_STEPS),
	localparam int unsigned TW = $clog2(RANDOM_PERIOD + 1)
) (
	input  wire lfe_item_t   item,
	input  wire logic [2:0]  mode,
	input  wire logic [PW-1:0] phase,
	input  wire logic [TW-1:0] tick,
	input  wire lfe_levels_t lv,
	output logic [2:0]       mode_nx,
	output logic [PW-1:0]    phase_nx,
	output logic [TW-1:0]    tick_nx,
	output lfe_levels_t      lv_nx
);

	// The table index is the next phase * 128 / SINE_STEPS, taken as a multiply by a
	// rounded-up reciprocal; the shift is wide enough for the floor to be exact.
	localparam int unsigned NW = PW + 7;
	localparam int unsigned K  = NW + PW;
	localparam int unsigned MW = NW + 2;
	localparam int unsigned PRW = NW + MW;
	localparam longint unsigned RECIP = ((64'd1 << K) + SINE_STEPS - 1) / SINE_STEPS;

	logic [7:0]     r;
	logic [PW-1:0]  phase_inc;
	logic [NW-1:0]  scaled;
	logic [PRW-1:0] prod;
	logic [6:0]     idx;
	lfe_levels_t    rb1;
	lfe_levels_t    rb2;

	assign r = mod255(item.random_level);

	assign phase_inc = (phase == PW'(SINE_STEPS - 1)) ? '0 : phase + PW'(1);
	assign scaled    = {phase_inc, 7'd0};
	assign prod      = PRW'(scaled) * PRW'(RECIP);
	assign idx       = prod[K+6:K];

	always_comb begin
		rb1 = lv;
		if (lv.blue == LEVEL_OFF && lv.red == LEVEL_FULL && lv.green != LEVEL_FULL) begin
			rb1.green = lv.green + 8'd1;
		end else if (lv.blue == LEVEL_OFF && lv.green == LEVEL_FULL && lv.red != LEVEL_OFF) begin
			rb1.red = lv.red - 8'd1;
		end else if (lv.red == LEVEL_OFF && lv.green == LEVEL_FULL && lv.blue != LEVEL_FULL) begin
			rb1.blue = lv.blue + 8'd1;
		end else if (lv.red == LEVEL_OFF && lv.blue == LEVEL_FULL && lv.green != LEVEL_OFF) begin
			rb1.green = lv.green - 8'd1;
		end
		rb2 = rb1;
		if (rb1.green == LEVEL_OFF && rb1.blue == LEVEL_FULL && rb1.red != LEVEL_FULL) begin
			rb2.red = rb1.red + 8'd1;
		end else if (rb1.green == LEVEL_OFF && rb1.red == LEVEL_FULL && rb1.blue != LEVEL_OFF) begin
			rb2.blue = rb1.blue - 8'd1;
		end
	end

	always_comb begin
		mode_nx  = mode;
		phase_nx = phase;
		tick_nx  = tick;
		lv_nx    = lv;
		if (item.func == FUNC_START) begin
			mode_nx = item.effect;
			if (item.effect == EFF_SINE || item.effect == EFF_LINEAR
					|| item.effect == EFF_RANDOM) begin
				lv_nx.dim = r;
			end else if (item.effect == EFF_RAINBOW) begin
				case (item.random_pick)
					PICK_RED: begin
						lv_nx.red   = LEVEL_FULL;
						lv_nx.green = r;
						lv_nx.blue  = LEVEL_OFF;
					end
					PICK_GREEN: begin
						lv_nx.green = LEVEL_FULL;
						lv_nx.blue  = r;
						lv_nx.red   = LEVEL_OFF;
					end
					PICK_BLUE: begin
						lv_nx.blue  = LEVEL_FULL;
						lv_nx.red   = r;
						lv_nx.green = LEVEL_OFF;
					end
					default: begin
						lv_nx = lv;
					end
				endcase
			end
		end else begin
			case (mode)
				EFF_SINE: begin
					phase_nx  = phase_inc;
					lv_nx.dim = SINE_TABLE[idx];
				end
				EFF_LINEAR: begin
					lv_nx.dim = lv.dim - 8'd1;
				end
				EFF_RANDOM: begin
					if (tick == '0) begin
						lv_nx.dim = (r < RANDOM_FLOOR) ? RANDOM_FLOOR : r;
					end
				end
				EFF_RAINBOW: begin
					lv_nx = rb2;
				end
				default: begin
					lv_nx = lv;
				end
			endcase
			tick_nx = (tick == TW'(RANDOM_PERIOD - 1)) ? '0 : tick + TW'(1);
		end
	end

endmodule
`default_nettype wire

// ----- sv/led_fixture_effect_engine.sv -----
// Channel  | Handshake                  | Payload
// item     | item_valid / item_ready     | func, effect, random_level, random_pick
// result   | result_valid / result_ready | dimmer_level, red_level, green_level, blue_level
//
// Each transaction passes an input register and then the fixture state registers,
// which also serve as the result register.
// One transaction per cycle is sustained while the result is not stalled; the single
// update step between the input register and the state sets that figure.
// A stalled result holds the state; item_ready falls while the input register holds
// a transaction that cannot advance, so at most one further transaction is taken
// during a stall. Reset clears the effect, phase, tick count and all levels at once.
`default_nettype none
module led_fixture_effect_engine import lfe_pkg::*; #(
	parameter int unsigned SINE_STEPS    = SINE_STEPS_DEF,
	parameter int unsigned RANDOM_PERIOD = RANDOM_PERIOD_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       item_valid,
	output logic            item_ready,
	input  wire logic       func,
	input  wire logic [2:0] effect,
	input  wire logic [7:0] random_level,
	input  wire logic [1:0] random_pick,
	output logic            result_valid,
	input  wire logic       result_ready,
	output logic [7:0]      dimmer_level,
	output logic [7:0]      red_level,
	output logic [7:0]      green_level,
	output logic [7:0]      blue_level
);

	localparam int unsigned PW = $clog2(SINE_STEPS);
	localparam int unsigned TW = $clog2(RANDOM_PERIOD + 1);

	logic        valid_s1;
	lfe_item_t   item_s1;
	logic        advance;

	logic [2:0]    mode_q;
	logic [PW-1:0] phase_q;
	logic [TW-1:0] tick_q;
	lfe_levels_t   lv_q;
	logic          res_valid_q;

	logic [2:0]    mode_nx;
	logic [PW-1:0] phase_nx;
	logic [TW-1:0] tick_nx;
	lfe_levels_t   lv_nx;

	assign advance    = valid_s1 && (!res_valid_q || result_ready);
	assign item_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= '{func: func, effect: effect, random_level: random_level,
				random_pick: random_pick};
		end
	end

	lfe_step #(
		.SINE_STEPS(SINE_STEPS),
		.RANDOM_PERIOD(RANDOM_PERIOD)
	) u_step (
		.item(item_s1),
		.mode(mode_q),
		.phase(phase_q),
		.tick(tick_q),
		.lv(lv_q),
		.mode_nx(mode_nx),
		.phase_nx(phase_nx),
		.tick_nx(tick_nx),
		.lv_nx(lv_nx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= EFF_NONE;
			phase_q     <= '0;
			tick_q      <= '0;
			lv_q        <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				mode_q  <= mode_nx;
				phase_q <= phase_nx;
				tick_q  <= tick_nx;
				lv_q    <= lv_nx;
			end
			if (advance) begin
				res_valid_q <= 1'b1;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = res_valid_q;
	assign dimmer_level = lv_q.dim;
	assign red_level    = lv_q.red;
	assign green_level  = lv_q.green;
	assign blue_level   = lv_q.blue;

	a_tick_range: assert property (@(posedge clk) disable iff (!arst_n)
		tick_q < TW'(RANDOM_PERIOD))
		else $error("Tick count out of range.");

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q < PW'(SINE_STEPS - 1) || phase_q == PW'(SINE_STEPS - 1))
		else $error("Sine phase out of range.");

	a_linear_step: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.func == FUNC_TICK && mode_q == EFF_LINEAR
		|=> lv_q.dim == $past(lv_q.dim) - 8'd1)
		else $error("Linear tick did not step the dimmer down by one.");

	a_random_floor: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.func == FUNC_TICK && mode_q == EFF_RANDOM && tick_q == '0
		|=> lv_q.dim >= RANDOM_FLOOR)
		else $error("Random dimmer fell below its floor.");

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !result_ready |=> res_valid_q && $stable(lv_q))
		else $error("Levels changed while the result transaction was stalled.");

endmodule
`default_nettype wire
